// File: rtl/markup_source_tokenizer_unit_macros.svh
// Assertion macros shared by the tokenizer's checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MARKUP_SOURCE_TOKENIZER_UNIT_MACROS_SVH
`define MARKUP_SOURCE_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MST_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MST_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mst_pkg.sv
// Shared types, token codes, character constants and classifier functions
// for the markup source tokenizer. No dependencies.
`default_nettype none

package mst_pkg;

  // Width of the internal line and column counters.
  localparam int POS_BITS = 16;
  // Width of the line and column fields on the result channel.
  localparam int OUT_POS_W = 16;

  // Token kinds.
  localparam logic [5:0] TK_IDENT     = 6'd0;
  localparam logic [5:0] TK_NUMBER    = 6'd1;
  localparam logic [5:0] TK_STRING    = 6'd2;
  localparam logic [5:0] TK_LBRACE    = 6'd3;
  localparam logic [5:0] TK_RBRACE    = 6'd4;
  localparam logic [5:0] TK_LBRACKET  = 6'd5;
  localparam logic [5:0] TK_RBRACKET  = 6'd6;
  localparam logic [5:0] TK_LPAREN    = 6'd7;
  localparam logic [5:0] TK_RPAREN    = 6'd8;
  localparam logic [5:0] TK_COLON     = 6'd9;
  localparam logic [5:0] TK_EQUAL     = 6'd10;
  localparam logic [5:0] TK_SEMICOLON = 6'd11;
  localparam logic [5:0] TK_COMMA     = 6'd12;
  localparam logic [5:0] TK_AT        = 6'd13;
  localparam logic [5:0] TK_HASH      = 6'd14;
  localparam logic [5:0] TK_SLASH     = 6'd15;
  localparam logic [5:0] TK_DOT       = 6'd16;
  localparam logic [5:0] TK_PLUS      = 6'd17;
  localparam logic [5:0] TK_MINUS     = 6'd18;
  localparam logic [5:0] TK_STAR      = 6'd19;
  localparam logic [5:0] TK_PERCENT   = 6'd21;
  localparam logic [5:0] TK_CARET     = 6'd22;
  localparam logic [5:0] TK_GREATER   = 6'd23;
  localparam logic [5:0] TK_LESS      = 6'd24;
  localparam logic [5:0] TK_QUESTION  = 6'd25;
  localparam logic [5:0] TK_PIPE      = 6'd26;
  localparam logic [5:0] TK_AMPERSAND = 6'd27;
  localparam logic [5:0] TK_ARROW     = 6'd28;
  localparam logic [5:0] TK_CEEQUAL   = 6'd29;
  localparam logic [5:0] TK_EOF       = 6'd31;
  localparam logic [5:0] TK_ERROR     = 6'd32;
  // Marks a byte that is not one-character punctuation.
  localparam logic [5:0] TK_NONE      = 6'd63;

  // Record kinds and error causes.
  localparam logic RK_LEXEME = 1'b0;
  localparam logic RK_END    = 1'b1;
  localparam logic [1:0] EC_NONE       = 2'd0;
  localparam logic [1:0] EC_OPEN_STR   = 2'd1;
  localparam logic [1:0] EC_UNEXPECTED = 2'd2;

  // Characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;

  // One result record as it sits in the output queue.
  typedef struct packed {
    logic                 record_kind;
    logic [5:0]           token_kind;
    logic [7:0]           lexeme_value;
    logic [1:0]           error_cause;
    logic [OUT_POS_W-1:0] line_number;
    logic [OUT_POS_W-1:0] column_number;
    logic                 last_of_run;
  } rec_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  // One-character punctuation lookup; TK_NONE for anything else.
  function automatic logic [5:0] punct_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      8'h5B:   k = TK_LBRACKET;
      8'h5D:   k = TK_RBRACKET;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h3D:   k = TK_EQUAL;
      8'h3B:   k = TK_SEMICOLON;
      8'h2C:   k = TK_COMMA;
      8'h40:   k = TK_AT;
      8'h23:   k = TK_HASH;
      8'h2E:   k = TK_DOT;
      8'h2B:   k = TK_PLUS;
      8'h2A:   k = TK_STAR;
      8'h25:   k = TK_PERCENT;
      8'h5E:   k = TK_CARET;
      8'h3E:   k = TK_GREATER;
      8'h3C:   k = TK_LESS;
      8'h3F:   k = TK_QUESTION;
      8'h7C:   k = TK_PIPE;
      8'h26:   k = TK_AMPERSAND;
      default: k = TK_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: rtl/markup_source_tokenizer_unit.sv
// Streaming tokenizer for markup source text, one byte per transfer.
// Depends on mst_pkg for token codes, characters, the record type and classifiers.
`default_nettype none

// The block takes source text one byte per input transfer and produces token
// records on the result channel. A byte transfer is registered, then decoded
// in the next cycle against the lexer state; the zero, one or two records it
// causes go into a two-entry output queue whose head drives the out_ ports.
// A byte of value zero, or in_is_end high, ends the text: an open token is
// closed, an open string becomes an error token, and an EndOfFile record
// follows, after which the line and column restart at one.
// Rate: one input transfer per cycle as long as each byte gives at most one
// record and the output is not stalled. The output port carries one record
// per cycle when not stalled, so every byte that closes a token and also
// starts or ends another adds a record to the backlog: the queue absorbs one
// such extra record, and when a further two-record byte arrives while it is
// still held, the input is stalled until the queue has room.
// Order: a byte waits in the input register until the queue has room for all
// of its records, which then enter the queue and reach the ports from its
// head. Identifiers, numbers and held punctuation ('/', ':', '-') are closed
// only when the following byte shows the token has ended, so their token-end
// record appears with that following byte.
module markup_source_tokenizer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_is_end,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_record_kind,
  output      logic [5:0]  out_token_kind,
  output      logic [7:0]  out_lexeme_value,
  output      logic [1:0]  out_error_cause,
  output      logic [mst_pkg::OUT_POS_W-1:0] out_line_number,
  output      logic [mst_pkg::OUT_POS_W-1:0] out_column_number,
  output      logic        out_last_of_run
);

  // Lexer modes. Codes beyond the named ones behave as idle.
  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_IDENT = 4'd1,
    M_INT   = 4'd2,
    M_FRAC  = 4'd3,
    M_STR   = 4'd4,
    M_ESC   = 4'd5,
    M_SLASH = 4'd6,
    M_LCMT  = 4'd7,
    M_BCMT  = 4'd8,
    M_BSTAR = 4'd9,
    M_COLON = 4'd10,
    M_MINUS = 4'd11
  } mode_t;

  localparam logic [mst_pkg::POS_BITS-1:0] POS_ONE = mst_pkg::POS_BITS'(1);
  localparam logic [mst_pkg::POS_BITS-1:0] POS_TOP = '1;

  // Input register.
  logic       item_v_r, item_v_nxt;
  logic [7:0] byte_r;
  logic       end_r;

  // Lexer state.
  mode_t                         mode_r, mode_nxt;
  logic [7:0]                    quote_r, quote_nxt;
  logic [mst_pkg::POS_BITS-1:0]  line_r, line_nxt;
  logic [mst_pkg::POS_BITS-1:0]  col_r, col_nxt;

  // Output queue: entry 0 is the head shown on the ports.
  mst_pkg::rec_t q_r   [2];
  mst_pkg::rec_t q_nxt [2];
  logic [1:0]    cnt_r, cnt_nxt;

  // Decode of the registered byte.
  logic        eof;
  logic        run_idle;
  logic        close_v;
  logic [5:0]  close_tk;
  logic [7:0]  close_val;
  logic [1:0]  close_cause;
  logic        b_v;
  logic        b_rk;
  logic [5:0]  b_tk;
  logic [7:0]  b_val;
  logic [1:0]  b_cause;
  logic [5:0]  pk;
  logic [7:0]  esc_val;
  logic [mst_pkg::POS_BITS-1:0] line_cons, col_cons;
  mst_pkg::rec_t rec_a, rec_b, rec_first;

  // Handshake and queue bookkeeping.
  logic       pop;
  logic       proc;
  logic [1:0] n_res;
  logic [1:0] cnt_pop;
  logic [1:0] room;

  assign eof = end_r || (byte_r == mst_pkg::CH_NUL);
  assign pk  = mst_pkg::punct_kind(byte_r);

  // Escape decoding: n, t and r map to control codes, anything else is literal.
  always_comb begin
    case (byte_r)
      mst_pkg::CH_LC_N: esc_val = mst_pkg::CH_LF;
      mst_pkg::CH_LC_T: esc_val = mst_pkg::CH_TAB;
      mst_pkg::CH_LC_R: esc_val = mst_pkg::CH_CR;
      default:          esc_val = byte_r;
    endcase
  end

  // Every byte that is not an end marker moves the position exactly once.
  always_comb begin
    line_cons = line_r;
    col_cons  = col_r;
    if (!eof) begin
      if (byte_r == mst_pkg::CH_LF) begin
        if (line_r != POS_TOP) line_cons = line_r + POS_ONE;
        col_cons = POS_ONE;
      end else if (col_r != POS_TOP) begin
        col_cons = col_r + POS_ONE;
      end
    end
  end

  // Next-mode function. A "close" record ends the token held from earlier
  // bytes; the "b" record is whatever the byte itself produces.
  always_comb begin
    close_v     = 1'b0;
    close_tk    = mst_pkg::TK_IDENT;
    close_val   = 8'h00;
    close_cause = mst_pkg::EC_NONE;
    b_v         = 1'b0;
    b_rk        = mst_pkg::RK_LEXEME;
    b_tk        = mst_pkg::TK_IDENT;
    b_val       = byte_r;
    b_cause     = mst_pkg::EC_NONE;
    run_idle    = 1'b0;
    mode_nxt    = mode_r;
    quote_nxt   = quote_r;

    unique case (mode_r) inside
      M_IDENT: begin
        if (!eof && (mst_pkg::is_alpha(byte_r) || mst_pkg::is_digit(byte_r) ||
                     byte_r == mst_pkg::CH_UNDER || byte_r == mst_pkg::CH_HYPHEN)) begin
          b_v  = 1'b1;
          b_tk = mst_pkg::TK_IDENT;
        end else begin
          close_v  = 1'b1;
          close_tk = mst_pkg::TK_IDENT;
          run_idle = 1'b1;
        end
      end
      M_INT, M_FRAC: begin
        if (!eof && mst_pkg::is_digit(byte_r)) begin
          b_v  = 1'b1;
          b_tk = mst_pkg::TK_NUMBER;
        end else if (!eof && byte_r == mst_pkg::CH_DOT && mode_r == M_INT) begin
          b_v      = 1'b1;
          b_tk     = mst_pkg::TK_NUMBER;
          mode_nxt = M_FRAC;
        end else begin
          close_v  = 1'b1;
          close_tk = mst_pkg::TK_NUMBER;
          run_idle = 1'b1;
        end
      end
      M_STR, M_ESC: begin
        if (eof) begin
          close_v     = 1'b1;
          close_tk    = mst_pkg::TK_ERROR;
          close_cause = mst_pkg::EC_OPEN_STR;
          run_idle    = 1'b1;
        end else if (mode_r == M_ESC) begin
          b_v      = 1'b1;
          b_tk     = mst_pkg::TK_STRING;
          b_val    = esc_val;
          mode_nxt = M_STR;
        end else if (byte_r == quote_r) begin
          b_v      = 1'b1;
          b_rk     = mst_pkg::RK_END;
          b_tk     = mst_pkg::TK_STRING;
          b_val    = 8'h00;
          mode_nxt = M_IDLE;
        end else if (byte_r == mst_pkg::CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else begin
          b_v  = 1'b1;
          b_tk = mst_pkg::TK_STRING;
        end
      end
      M_SLASH: begin
        if (!eof && byte_r == mst_pkg::CH_SLASH) begin
          mode_nxt = M_LCMT;
        end else if (!eof && byte_r == mst_pkg::CH_STAR) begin
          mode_nxt = M_BCMT;
        end else begin
          close_v   = 1'b1;
          close_tk  = mst_pkg::TK_SLASH;
          close_val = mst_pkg::CH_SLASH;
          run_idle  = 1'b1;
        end
      end
      M_LCMT: begin
        if (eof) begin
          run_idle = 1'b1;
        end else if (byte_r == mst_pkg::CH_LF) begin
          mode_nxt = M_IDLE;
        end
      end
      M_BCMT, M_BSTAR: begin
        if (eof) begin
          run_idle = 1'b1;
        end else if (byte_r == mst_pkg::CH_STAR) begin
          mode_nxt = M_BSTAR;
        end else if (byte_r == mst_pkg::CH_SLASH && mode_r == M_BSTAR) begin
          mode_nxt = M_IDLE;
        end else begin
          mode_nxt = M_BCMT;
        end
      end
      M_COLON: begin
        if (!eof && byte_r == mst_pkg::CH_EQUAL) begin
          b_v      = 1'b1;
          b_rk     = mst_pkg::RK_END;
          b_tk     = mst_pkg::TK_CEEQUAL;
          mode_nxt = M_IDLE;
        end else begin
          close_v   = 1'b1;
          close_tk  = mst_pkg::TK_COLON;
          close_val = mst_pkg::CH_COLON;
          run_idle  = 1'b1;
        end
      end
      M_MINUS: begin
        if (!eof && byte_r == mst_pkg::CH_GT) begin
          b_v      = 1'b1;
          b_rk     = mst_pkg::RK_END;
          b_tk     = mst_pkg::TK_ARROW;
          mode_nxt = M_IDLE;
        end else begin
          close_v   = 1'b1;
          close_tk  = mst_pkg::TK_MINUS;
          close_val = mst_pkg::CH_HYPHEN;
          run_idle  = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    // The byte is handled from idle: either nothing was open, or the open
    // token has just been closed.
    if (run_idle) begin
      mode_nxt = M_IDLE;
      if (eof) begin
        b_v       = 1'b1;
        b_rk      = mst_pkg::RK_END;
        b_tk      = mst_pkg::TK_EOF;
        b_val     = 8'h00;
        quote_nxt = 8'h00;
      end else if (mst_pkg::is_space(byte_r)) begin
        b_v = 1'b0;
      end else if (byte_r == mst_pkg::CH_DQUOTE || byte_r == mst_pkg::CH_SQUOTE) begin
        quote_nxt = byte_r;
        mode_nxt  = M_STR;
      end else if (mst_pkg::is_digit(byte_r)) begin
        b_v      = 1'b1;
        b_tk     = mst_pkg::TK_NUMBER;
        mode_nxt = M_INT;
      end else if (mst_pkg::is_alpha(byte_r) || byte_r == mst_pkg::CH_UNDER) begin
        b_v      = 1'b1;
        b_tk     = mst_pkg::TK_IDENT;
        mode_nxt = M_IDENT;
      end else if (byte_r == mst_pkg::CH_SLASH) begin
        mode_nxt = M_SLASH;
      end else if (byte_r == mst_pkg::CH_COLON) begin
        mode_nxt = M_COLON;
      end else if (byte_r == mst_pkg::CH_HYPHEN) begin
        mode_nxt = M_MINUS;
      end else if (pk != mst_pkg::TK_NONE) begin
        b_v  = 1'b1;
        b_rk = mst_pkg::RK_END;
        b_tk = pk;
      end else begin
        b_v     = 1'b1;
        b_rk    = mst_pkg::RK_END;
        b_tk    = mst_pkg::TK_ERROR;
        b_cause = mst_pkg::EC_UNEXPECTED;
      end
    end
  end

  // The closing record carries the position before this byte; the byte's own
  // record carries the position after it.
  always_comb begin
    rec_a.record_kind   = mst_pkg::RK_END;
    rec_a.token_kind    = close_tk;
    rec_a.lexeme_value  = close_val;
    rec_a.error_cause   = close_cause;
    rec_a.line_number   = mst_pkg::OUT_POS_W'(line_r);
    rec_a.column_number = mst_pkg::OUT_POS_W'(col_r);
    rec_a.last_of_run   = !b_v;

    rec_b.record_kind   = b_rk;
    rec_b.token_kind    = b_tk;
    rec_b.lexeme_value  = b_val;
    rec_b.error_cause   = b_cause;
    rec_b.line_number   = mst_pkg::OUT_POS_W'(line_cons);
    rec_b.column_number = mst_pkg::OUT_POS_W'(col_cons);
    rec_b.last_of_run   = 1'b1;

    rec_first = close_v ? rec_a : rec_b;
  end

  // The registered byte is retired only when the queue has room for all of
  // its records after this cycle's output transfer.
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign n_res     = {1'b0, close_v} + {1'b0, b_v};
  assign cnt_pop   = cnt_r - {1'b0, pop};
  assign room      = 2'd2 - cnt_pop;
  assign proc      = item_v_r && (n_res <= room);
  assign in_stall  = item_v_r && !proc;

  always_comb begin
    item_v_nxt = item_v_r;
    if (in_valid && !in_stall) begin
      item_v_nxt = 1'b1;
    end else if (proc) begin
      item_v_nxt = 1'b0;
    end

    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    if (proc && n_res != 2'd0) begin
      if (cnt_pop == 2'd0) begin
        q_nxt[0] = rec_first;
        if (n_res == 2'd2) q_nxt[1] = rec_b;
      end else begin
        q_nxt[1] = rec_first;
      end
    end
    cnt_nxt = cnt_pop + (proc ? n_res : 2'd0);

    // The end marker restarts the position for the next text.
    line_nxt = line_cons;
    col_nxt  = col_cons;
    if (run_idle && eof) begin
      line_nxt = POS_ONE;
      col_nxt  = POS_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      mode_r   <= M_IDLE;
      quote_r  <= 8'h00;
      line_r   <= POS_ONE;
      col_r    <= POS_ONE;
      cnt_r    <= 2'd0;
    end else begin
      item_v_r <= item_v_nxt;
      cnt_r    <= cnt_nxt;
      if (proc) begin
        mode_r  <= mode_nxt;
        quote_r <= quote_nxt;
        line_r  <= line_nxt;
        col_r   <= col_nxt;
      end
    end
    if (in_valid && !in_stall) begin
      byte_r <= in_data_byte;
      end_r  <= in_is_end;
    end
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_record_kind   = q_r[0].record_kind;
  assign out_token_kind    = q_r[0].token_kind;
  assign out_lexeme_value  = q_r[0].lexeme_value;
  assign out_error_cause   = q_r[0].error_cause;
  assign out_line_number   = q_r[0].line_number;
  assign out_column_number = q_r[0].column_number;
  assign out_last_of_run   = q_r[0].last_of_run;

endmodule

`default_nettype wire

// File: rtl/mst_checker.sv
// Port-level checker for the markup source tokenizer, bound to its top level.
// Depends on mst_pkg and on the shared assertion macro header.
`default_nettype none
`include "markup_source_tokenizer_unit_macros.svh"

module mst_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_data_byte,
  input wire logic        in_is_end,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_record_kind,
  input wire logic [5:0]  out_token_kind,
  input wire logic [7:0]  out_lexeme_value,
  input wire logic [1:0]  out_error_cause,
  input wire logic [mst_pkg::OUT_POS_W-1:0] out_line_number,
  input wire logic [mst_pkg::OUT_POS_W-1:0] out_column_number,
  input wire logic        out_last_of_run
);

  // A stalled result keeps its token kind, lexeme value and column until it is taken.
  `MST_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_token_kind) && $stable(out_lexeme_value) && $stable(out_column_number), "result changed while stalled")

  // End of file is always a token end and the final record of its byte.
  `MST_ASSERT_IMP(a_eof_end, out_valid && out_token_kind == mst_pkg::TK_EOF, out_record_kind == mst_pkg::RK_END && out_last_of_run, "end of file record malformed")

  // Lexeme records belong only to identifiers, numbers and strings.
  `MST_ASSERT_IMP(a_lexeme_kind, out_valid && out_record_kind == mst_pkg::RK_LEXEME, out_error_cause == mst_pkg::EC_NONE && (out_token_kind == mst_pkg::TK_IDENT || out_token_kind == mst_pkg::TK_NUMBER || out_token_kind == mst_pkg::TK_STRING), "bad lexeme record")

  // An error cause is reported only on an error token.
  `MST_ASSERT_IMP(a_cause_kind, out_valid && out_error_cause != mst_pkg::EC_NONE, out_token_kind == mst_pkg::TK_ERROR && out_record_kind == mst_pkg::RK_END, "error cause on non-error token")

endmodule

bind markup_source_tokenizer_unit mst_checker u_mst_checker (.*);

`default_nettype wire

// File: verif/tb_markup_source_tokenizer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for markup_source_tokenizer_unit: directed rows and
// random source text, checked against hand-typed records or a lexer written here.
// Depends on mst_pkg for token codes, character codes and the record type.

module tb_markup_source_tokenizer_unit;

  // Cycles without any transfer on either channel before the run is declared hung.
  // The slowest legal stretch is a sender gap plus two stalled records, far below this.
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1010;
  localparam int TAIL_CYCLES  = 20;
  localparam mst_pkg::rec_t NO_REC = '0;

  // One source byte as it is offered to the block. Rows of the directed table can
  // carry up to two records typed in by hand; all other items use the lexer below.
  typedef struct packed {
    logic [7:0]    data;
    logic          fin;
    logic          fixed;
    logic [1:0]    n_fixed;
    mst_pkg::rec_t first;
    mst_pkg::rec_t second;
  } src_item_t;

  // Scanner modes of the local lexer.
  typedef enum logic [3:0] {
    LX_IDLE, LX_WORD, LX_INT, LX_FRAC, LX_QUOTED, LX_ESCAPE, LX_SLASH,
    LX_LINE_NOTE, LX_BLOCK_NOTE, LX_BLOCK_STAR, LX_COLON, LX_MINUS
  } lex_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_is_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_record_kind;
  logic [5:0]  out_token_kind;
  logic [7:0]  out_lexeme_value;
  logic [1:0]  out_error_cause;
  logic [15:0] out_line_number;
  logic [15:0] out_column_number;
  logic        out_last_of_run;

  // Local lexer state, mirrored from what the block should hold.
  lex_state_t                   lx_state;
  logic [7:0]                   lx_quote;
  logic [mst_pkg::POS_BITS-1:0] lx_line;
  logic [mst_pkg::POS_BITS-1:0] lx_col;
  mst_pkg::rec_t                step_recs [2];
  int                           step_cnt;

  src_item_t     text_q [$];          // source bytes waiting to be offered
  src_item_t     offered_q [$];       // bytes on the input port, oldest first
  mst_pkg::rec_t pending_records [$]; // token records the block still owes us
  src_item_t     cur_item;
  mst_pkg::rec_t seen_rec;
  mst_pkg::rec_t wanted_rec;
  int            bad_count = 0;
  int            idle_cycles = 0;
  bit            no_gaps = 1'b0;

  string punct_chars = "{}[]()=;,@#.+*%^><?|&";
  string blank_chars = " \t\r\n";

  // Directed rows. Records are typed in where they follow at a glance: punctuation
  // right after reset, an unexpected high byte, an unterminated string at end of text,
  // and an end flag whose byte is ignored. Every other row goes through the lexer.
  src_item_t directed_rows [29] = '{
    '{"{", 1'b0, 1'b1, 2'd1,
      '{mst_pkg::RK_END, mst_pkg::TK_LBRACE, 8'h7B, mst_pkg::EC_NONE, 16'd1, 16'd2, 1'b1},
      NO_REC},
    '{8'hFF, 1'b0, 1'b1, 2'd1,
      '{mst_pkg::RK_END, mst_pkg::TK_ERROR, 8'hFF, mst_pkg::EC_UNEXPECTED,
        16'd1, 16'd3, 1'b1},
      NO_REC},
    '{"a", 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},                 // identifier opens
    '{mst_pkg::CH_HYPHEN, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},  // hyphen continues it
    '{"9", 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_COLON, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},   // closes identifier
    '{mst_pkg::CH_EQUAL, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},   // := pair
    '{mst_pkg::CH_HYPHEN, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_GT, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},      // -> pair
    '{mst_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_STAR, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},    // block comment opens
    '{mst_pkg::CH_STAR, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},   // and closes
    '{mst_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_LC_N, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},    // decodes to a line feed
    '{mst_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{"1", 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_DOT, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},     // fraction point
    '{"5", 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_DOT, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},     // second point: two records
    '{mst_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},   // line comment
    '{mst_pkg::CH_LF, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_SQUOTE, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_NUL, 1'b0, 1'b1, 2'd2,
      '{mst_pkg::RK_END, mst_pkg::TK_ERROR, 8'h00, mst_pkg::EC_OPEN_STR,
        16'd2, 16'd2, 1'b0},
      '{mst_pkg::RK_END, mst_pkg::TK_EOF, 8'h00, mst_pkg::EC_NONE, 16'd2, 16'd2, 1'b1}},
    '{"x", 1'b1, 1'b1, 2'd1,
      '{mst_pkg::RK_END, mst_pkg::TK_EOF, 8'h00, mst_pkg::EC_NONE, 16'd1, 16'd1, 1'b1},
      NO_REC},
    '{mst_pkg::CH_UNDER, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC},
    '{mst_pkg::CH_TAB, 1'b0, 1'b0, 2'd0, NO_REC, NO_REC}
  };

  markup_source_tokenizer_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_is_end         (in_is_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_record_kind   (out_record_kind),
    .out_token_kind    (out_token_kind),
    .out_lexeme_value  (out_lexeme_value),
    .out_error_cause   (out_error_cause),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number),
    .out_last_of_run   (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local lexer. It advances on every accepted byte and leaves the records that
  // byte causes in step_recs[0 .. step_cnt-1].
  // ---------------------------------------------------------------------------

  function automatic bit is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [5:0] punct_code(input logic [7:0] c);
    case (c)
      "{": return mst_pkg::TK_LBRACE;
      "}": return mst_pkg::TK_RBRACE;
      "[": return mst_pkg::TK_LBRACKET;
      "]": return mst_pkg::TK_RBRACKET;
      "(": return mst_pkg::TK_LPAREN;
      ")": return mst_pkg::TK_RPAREN;
      "=": return mst_pkg::TK_EQUAL;
      ";": return mst_pkg::TK_SEMICOLON;
      ",": return mst_pkg::TK_COMMA;
      "@": return mst_pkg::TK_AT;
      "#": return mst_pkg::TK_HASH;
      ".": return mst_pkg::TK_DOT;
      "+": return mst_pkg::TK_PLUS;
      "*": return mst_pkg::TK_STAR;
      "%": return mst_pkg::TK_PERCENT;
      "^": return mst_pkg::TK_CARET;
      ">": return mst_pkg::TK_GREATER;
      "<": return mst_pkg::TK_LESS;
      "?": return mst_pkg::TK_QUESTION;
      "|": return mst_pkg::TK_PIPE;
      "&": return mst_pkg::TK_AMPERSAND;
      default: return mst_pkg::TK_NONE;
    endcase
  endfunction

  function automatic void reset_lexer();
    lx_state = LX_IDLE;
    lx_quote = 8'h00;
    lx_line  = mst_pkg::POS_BITS'(1);
    lx_col   = mst_pkg::POS_BITS'(1);
  endfunction

  // Both counters stick at their top value instead of wrapping.
  function automatic void bump_pos(input logic [7:0] c);
    if (c == mst_pkg::CH_LF) begin
      if (lx_line != {mst_pkg::POS_BITS{1'b1}}) lx_line = lx_line + 1'b1;
      lx_col = mst_pkg::POS_BITS'(1);
    end else if (lx_col != {mst_pkg::POS_BITS{1'b1}}) begin
      lx_col = lx_col + 1'b1;
    end
  endfunction

  function automatic void add_rec(input logic rk, input logic [5:0] tk,
                                  input logic [7:0] val, input logic [1:0] cause);
    logic slot;
    if (step_cnt < 2) begin
      slot = 1'(step_cnt);
      step_recs[slot].record_kind   = rk;
      step_recs[slot].token_kind    = tk;
      step_recs[slot].lexeme_value  = val;
      step_recs[slot].error_cause   = cause;
      step_recs[slot].line_number   = lx_line[mst_pkg::OUT_POS_W-1:0];
      step_recs[slot].column_number = lx_col[mst_pkg::OUT_POS_W-1:0];
      step_recs[slot].last_of_run   = 1'b0;
      step_cnt++;
    end
  endfunction

  // Handles a byte as if no token were open. End of text also rewinds the position.
  function automatic void start_fresh(input logic [7:0] c, input logic fin);
    logic [5:0] tk;
    lx_state = LX_IDLE;
    if (fin) begin
      add_rec(mst_pkg::RK_END, mst_pkg::TK_EOF, 8'h00, mst_pkg::EC_NONE);
      lx_quote = 8'h00;
      lx_line  = mst_pkg::POS_BITS'(1);
      lx_col   = mst_pkg::POS_BITS'(1);
      return;
    end
    bump_pos(c);
    if (c == mst_pkg::CH_SPACE || c == mst_pkg::CH_TAB || c == mst_pkg::CH_CR ||
        c == mst_pkg::CH_LF) return;
    if (c == mst_pkg::CH_DQUOTE || c == mst_pkg::CH_SQUOTE) begin
      lx_quote = c;
      lx_state = LX_QUOTED;
    end else if (is_dec(c)) begin
      add_rec(mst_pkg::RK_LEXEME, mst_pkg::TK_NUMBER, c, mst_pkg::EC_NONE);
      lx_state = LX_INT;
    end else if (is_letter(c) || c == mst_pkg::CH_UNDER) begin
      add_rec(mst_pkg::RK_LEXEME, mst_pkg::TK_IDENT, c, mst_pkg::EC_NONE);
      lx_state = LX_WORD;
    end else if (c == mst_pkg::CH_SLASH) begin
      lx_state = LX_SLASH;
    end else if (c == mst_pkg::CH_COLON) begin
      lx_state = LX_COLON;
    end else if (c == mst_pkg::CH_HYPHEN) begin
      lx_state = LX_MINUS;
    end else begin
      tk = punct_code(c);
      if (tk != mst_pkg::TK_NONE) add_rec(mst_pkg::RK_END, tk, c, mst_pkg::EC_NONE);
      else add_rec(mst_pkg::RK_END, mst_pkg::TK_ERROR, c, mst_pkg::EC_UNEXPECTED);
    end
  endfunction

  function automatic void tokenize_byte(input logic [7:0] c, input logic end_flag);
    logic       fin;
    logic [7:0] dec;
    fin = end_flag || (c == mst_pkg::CH_NUL);
    step_cnt = 0;
    case (lx_state)
      LX_WORD: begin
        if (!fin && (is_letter(c) || is_dec(c) || c == mst_pkg::CH_UNDER ||
                     c == mst_pkg::CH_HYPHEN)) begin
          bump_pos(c);
          add_rec(mst_pkg::RK_LEXEME, mst_pkg::TK_IDENT, c, mst_pkg::EC_NONE);
        end else begin
          add_rec(mst_pkg::RK_END, mst_pkg::TK_IDENT, 8'h00, mst_pkg::EC_NONE);
          start_fresh(c, fin);
        end
      end
      LX_INT, LX_FRAC: begin
        if (!fin && is_dec(c)) begin
          bump_pos(c);
          add_rec(mst_pkg::RK_LEXEME, mst_pkg::TK_NUMBER, c, mst_pkg::EC_NONE);
        end else if (!fin && c == mst_pkg::CH_DOT && lx_state == LX_INT) begin
          bump_pos(c);
          add_rec(mst_pkg::RK_LEXEME, mst_pkg::TK_NUMBER, c, mst_pkg::EC_NONE);
          lx_state = LX_FRAC;
        end else begin
          add_rec(mst_pkg::RK_END, mst_pkg::TK_NUMBER, 8'h00, mst_pkg::EC_NONE);
          start_fresh(c, fin);
        end
      end
      LX_QUOTED, LX_ESCAPE: begin
        if (fin) begin
          add_rec(mst_pkg::RK_END, mst_pkg::TK_ERROR, 8'h00, mst_pkg::EC_OPEN_STR);
          start_fresh(c, fin);
        end else begin
          bump_pos(c);
          if (lx_state == LX_ESCAPE) begin
            dec = (c == mst_pkg::CH_LC_N) ? mst_pkg::CH_LF :
                  (c == mst_pkg::CH_LC_T) ? mst_pkg::CH_TAB :
                  (c == mst_pkg::CH_LC_R) ? mst_pkg::CH_CR : c;
            add_rec(mst_pkg::RK_LEXEME, mst_pkg::TK_STRING, dec, mst_pkg::EC_NONE);
            lx_state = LX_QUOTED;
          end else if (c == lx_quote) begin
            add_rec(mst_pkg::RK_END, mst_pkg::TK_STRING, 8'h00, mst_pkg::EC_NONE);
            lx_state = LX_IDLE;
          end else if (c == mst_pkg::CH_BSLASH) begin
            lx_state = LX_ESCAPE;
          end else begin
            add_rec(mst_pkg::RK_LEXEME, mst_pkg::TK_STRING, c, mst_pkg::EC_NONE);
          end
        end
      end
      LX_SLASH: begin
        if (!fin && c == mst_pkg::CH_SLASH) begin
          bump_pos(c);
          lx_state = LX_LINE_NOTE;
        end else if (!fin && c == mst_pkg::CH_STAR) begin
          bump_pos(c);
          lx_state = LX_BLOCK_NOTE;
        end else begin
          add_rec(mst_pkg::RK_END, mst_pkg::TK_SLASH, mst_pkg::CH_SLASH, mst_pkg::EC_NONE);
          start_fresh(c, fin);
        end
      end
      LX_LINE_NOTE: begin
        if (fin) begin
          start_fresh(c, fin);
        end else begin
          bump_pos(c);
          if (c == mst_pkg::CH_LF) lx_state = LX_IDLE;
        end
      end
      LX_BLOCK_NOTE, LX_BLOCK_STAR: begin
        if (fin) begin
          start_fresh(c, fin);
        end else begin
          bump_pos(c);
          if (c == mst_pkg::CH_STAR) lx_state = LX_BLOCK_STAR;
          else if (c == mst_pkg::CH_SLASH && lx_state == LX_BLOCK_STAR) lx_state = LX_IDLE;
          else lx_state = LX_BLOCK_NOTE;
        end
      end
      LX_COLON: begin
        if (!fin && c == mst_pkg::CH_EQUAL) begin
          bump_pos(c);
          add_rec(mst_pkg::RK_END, mst_pkg::TK_CEEQUAL, c, mst_pkg::EC_NONE);
          lx_state = LX_IDLE;
        end else begin
          add_rec(mst_pkg::RK_END, mst_pkg::TK_COLON, mst_pkg::CH_COLON, mst_pkg::EC_NONE);
          start_fresh(c, fin);
        end
      end
      LX_MINUS: begin
        if (!fin && c == mst_pkg::CH_GT) begin
          bump_pos(c);
          add_rec(mst_pkg::RK_END, mst_pkg::TK_ARROW, c, mst_pkg::EC_NONE);
          lx_state = LX_IDLE;
        end else begin
          add_rec(mst_pkg::RK_END, mst_pkg::TK_MINUS, mst_pkg::CH_HYPHEN, mst_pkg::EC_NONE);
          start_fresh(c, fin);
        end
      end
      default: start_fresh(c, fin);
    endcase
    if (step_cnt > 0) step_recs[1'(step_cnt - 1)].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Source text generation. Most snippets are well-formed tokens, comments and
  // whitespace with random content; the rest are stray bytes, unclosed strings or
  // comments, and ends of text that cut a token short.
  // ---------------------------------------------------------------------------

  function automatic src_item_t make_item(input logic [7:0] b, input logic fin);
    src_item_t it;
    it = '0;
    it.data = b;
    it.fin = fin;
    return it;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    text_q = {text_q, make_item(b, 1'b0)};
  endfunction

  function automatic logic [7:0] rand_word_char(input bit head);
    int unsigned r;
    r = head ? $urandom_range(0, 52) : $urandom_range(0, 63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return mst_pkg::CH_UNDER;
    if (r < 63) return 8'("0" + r - 53);
    return mst_pkg::CH_HYPHEN;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic void add_snippet();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  q;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      add_byte(rand_word_char(1'b1));
      len = $urandom_range(0, 6);
      repeat (len) add_byte(rand_word_char(1'b0));
    end else if (pick < 34) begin
      len = $urandom_range(1, 4);
      repeat (len) add_byte(rand_digit());
      if ($urandom_range(0, 2) == 0) begin
        add_byte(mst_pkg::CH_DOT);
        len = $urandom_range(0, 3);
        repeat (len) add_byte(rand_digit());
        // A second point ends the number and becomes a Dot token.
        if ($urandom_range(0, 3) == 0) add_byte(mst_pkg::CH_DOT);
      end
    end else if (pick < 50) begin
      q = $urandom_range(0, 1) ? mst_pkg::CH_DQUOTE : mst_pkg::CH_SQUOTE;
      add_byte(q);
      len = $urandom_range(0, 6);
      repeat (len) begin
        case ($urandom_range(0, 9))
          0: begin
            add_byte(mst_pkg::CH_BSLASH);
            case ($urandom_range(0, 3))
              0: add_byte(mst_pkg::CH_LC_N);
              1: add_byte(mst_pkg::CH_LC_T);
              2: add_byte(mst_pkg::CH_LC_R);
              default: add_byte(8'($urandom_range(1, 255)));
            endcase
          end
          1, 2, 3: add_byte(8'($urandom_range(1, 255)));
          default: add_byte(8'($urandom_range(32, 126)));
        endcase
      end
      // Some strings are left open and swallow whatever follows.
      if ($urandom_range(0, 9) != 0) add_byte(q);
    end else if (pick < 57) begin
      add_byte(mst_pkg::CH_SLASH);
      add_byte(mst_pkg::CH_SLASH);
      len = $urandom_range(0, 5);
      repeat (len) add_byte(8'($urandom_range(1, 255)));
      add_byte(mst_pkg::CH_LF);
    end else if (pick < 63) begin
      add_byte(mst_pkg::CH_SLASH);
      add_byte(mst_pkg::CH_STAR);
      len = $urandom_range(0, 6);
      repeat (len) begin
        add_byte($urandom_range(0, 3) == 0 ? mst_pkg::CH_STAR : 8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 9) != 0) begin
        add_byte(mst_pkg::CH_STAR);
        add_byte(mst_pkg::CH_SLASH);
      end
    end else if (pick < 75) begin
      case ($urandom_range(0, 5))
        0: begin add_byte(mst_pkg::CH_COLON); add_byte(mst_pkg::CH_EQUAL); end
        1: begin add_byte(mst_pkg::CH_HYPHEN); add_byte(mst_pkg::CH_GT); end
        2: add_byte(mst_pkg::CH_COLON);
        3: add_byte(mst_pkg::CH_HYPHEN);
        4: add_byte(mst_pkg::CH_SLASH);
        default: add_byte(8'(punct_chars[$urandom_range(0, punct_chars.len() - 1)]));
      endcase
    end else if (pick < 85) begin
      add_byte(8'(blank_chars[$urandom_range(0, 3)]));
    end else if (pick < 94) begin
      add_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(1, 127)));
    end else begin
      // End of text, either by the flag with a random ignored byte or by a zero byte.
      if ($urandom_range(0, 1)) text_q = {text_q, make_item(8'($urandom_range(0, 255)), 1'b1)};
      else add_byte(mst_pkg::CH_NUL);
    end
    // Tokens often abut directly so the lookahead paths see every kind of follower.
    if ($urandom_range(0, 1) == 0) add_byte(8'(blank_chars[$urandom_range(0, 3)]));
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. The sender may pause before each byte, except in bursts where
  // it drives back to back. Valid stays high between back-to-back bytes.
  // ---------------------------------------------------------------------------

  task automatic offer(input src_item_t it);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered_q = {offered_q, it};
    in_valid     <= 1'b1;
    in_data_byte <= it.data;
    in_is_end    <= it.fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends everything queued in text_q. With vary set, bursts without gaps come and
  // go at random; otherwise the whole batch goes out back to back.
  task automatic send_text(input bit vary);
    int sent;
    sent = 0;
    no_gaps = !vary;
    while (text_q.size() != 0) begin
      if (vary && sent % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      offer(text_q.pop_front());
      sent++;
    end
  endtask

  // Drops valid and holds off until every owed record has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
  endtask

  // Every accepted byte advances the local lexer. Rows with hand-typed records
  // queue those instead of the lexer's, so those rows check the block apart from the lexer.
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_lexer();
    end else if (in_valid && !in_stall) begin
      cur_item = (offered_q.size() != 0) ? offered_q.pop_front() : '0;
      tokenize_byte(in_data_byte, in_is_end);
      if (cur_item.fixed) begin
        if (cur_item.n_fixed > 0) pending_records = {pending_records, cur_item.first};
        if (cur_item.n_fixed > 1) pending_records = {pending_records, cur_item.second};
      end else begin
        for (int k = 0; k < step_cnt; k++) begin
          pending_records = {pending_records, step_recs[1'(k)]};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side. After each record transfer the receiver may stall, except
  // during bursts.
  // ---------------------------------------------------------------------------

  initial begin : record_sink
    int unsigned hold;
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic flag_bad(input string why, input mst_pkg::rec_t want,
                          input mst_pkg::rec_t got);
    bad_count++;
    if (bad_count <= 10) begin
      $display("%0t %s: expected kind=%0d tok=%0d val=%02h cause=%0d line=%0d col=%0d last=%0d",
               $time, why, want.record_kind, want.token_kind, want.lexeme_value,
               want.error_cause, want.line_number, want.column_number, want.last_of_run);
      $display("    got      kind=%0d tok=%0d val=%02h cause=%0d line=%0d col=%0d last=%0d",
               got.record_kind, got.token_kind, got.lexeme_value, got.error_cause,
               got.line_number, got.column_number, got.last_of_run);
    end
  endtask

  // Each record transfer is compared field by field against the oldest owed record.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_rec.record_kind   = out_record_kind;
      seen_rec.token_kind    = out_token_kind;
      seen_rec.lexeme_value  = out_lexeme_value;
      seen_rec.error_cause   = out_error_cause;
      seen_rec.line_number   = out_line_number;
      seen_rec.column_number = out_column_number;
      seen_rec.last_of_run   = out_last_of_run;
      if (pending_records.size() == 0) begin
        flag_bad("record with none owed", NO_REC, seen_rec);
      end else begin
        wanted_rec = pending_records.pop_front();
        if (seen_rec.record_kind !== wanted_rec.record_kind ||
            seen_rec.token_kind !== wanted_rec.token_kind ||
            seen_rec.lexeme_value !== wanted_rec.lexeme_value ||
            seen_rec.error_cause !== wanted_rec.error_cause ||
            seen_rec.line_number !== wanted_rec.line_number ||
            seen_rec.column_number !== wanted_rec.column_number ||
            seen_rec.last_of_run !== wanted_rec.last_of_run) begin
          flag_bad("record mismatch", wanted_rec, seen_rec);
        end
      end
    end
  end

  // Hang detection: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------

  initial begin : test_flow
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, then a full stop on the input until the output has caught up.
    foreach (directed_rows[i]) offer(directed_rows[i]);
    wait_drained();

    // Random source text, closed by a final end of text so nothing stays held.
    while (text_q.size() < RANDOM_ITEMS) add_snippet();
    text_q = {text_q, make_item(8'($urandom_range(0, 255)), 1'b1)};
    send_text(1'b1);

    no_gaps = 1'b0;
    wait_drained();
    // Stray records after the last expected one are caught during this tail.
    repeat (TAIL_CYCLES) @(posedge clk);
    bad_count += pending_records.size();
    if (bad_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
